// File: src/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// wsfd_pkg: shared types and codes for the WebSocket frame deframer
// Parse phases, result kinds, opcodes, error codes and the result record.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  // parse phases
  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_CLOSE   = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // opcodes
  localparam logic [3:0] OPC_CONT  = 4'h0;
  localparam logic [3:0] OPC_TEXT  = 4'h1;
  localparam logic [3:0] OPC_BIN   = 4'h2;
  localparam logic [3:0] OPC_CLOSE = 4'h8;
  localparam logic [3:0] OPC_PING  = 4'h9;
  localparam logic [3:0] OPC_PONG  = 4'hA;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_UNSUPP   = 3'd1;
  localparam logic [2:0] ERR_INVALID  = 3'd2;
  localparam logic [2:0] ERR_TOOLARGE = 3'd3;
  localparam logic [2:0] ERR_TOOSMALL = 3'd4;

  // 7-bit length escape codes
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // configuration register indexes
  localparam logic [7:0] REG_MAX_PAYLOAD = 8'd0;
  localparam logic [7:0] REG_MIN_PAYLOAD = 8'd1;

  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd65480;
  localparam logic [7:0]  MIN_PAYLOAD_RESET = 8'd0;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_out;
    logic       last;
    logic [3:0] frame_type;
    logic [2:0] error_code;
  } res_t;

endpackage

// File: src/websocket_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top: WebSocket frame deframer
// Two register stages, input and output; a result is formed from the input
// register and shows on out_* once the output register takes it.
// Throughput: one byte per cycle unless the output stalls; the input and
// output registers form a pipeline, each advancing when the next can take.
// Reset: synchronous, active low; clears parse state, limits go to defaults.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] data_out, [11:8] frame_type,
                                   // [14:12] error_code, [15] zero
  output logic        out_tlast,
  output logic [1:0]  out_tuser,   // [1:0] kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic           in_v_r;
  logic [7:0]     in_d_r;
  logic           out_v_r;
  wsfd_pkg::res_t out_r;
  logic [31:0]    max_payload_r;
  logic [7:0]     min_payload_r;
  logic           out_take;
  logic           step;
  logic           res_valid;
  wsfd_pkg::res_t res;

  assign out_take  = !out_v_r || out_tready;
  assign in_tready = !in_v_r || out_take;
  assign step      = in_v_r && out_take;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= wsfd_pkg::MAX_PAYLOAD_RESET;
      min_payload_r <= wsfd_pkg::MIN_PAYLOAD_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == wsfd_pkg::REG_MAX_PAYLOAD) begin
        max_payload_r <= cfg_data;
      end else if (cfg_index == wsfd_pkg::REG_MIN_PAYLOAD) begin
        min_payload_r <= cfg_data[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_d_r <= in_tdata;
    end
  end

  wsfd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .data_byte   (in_d_r),
    .max_payload (max_payload_r),
    .min_payload (min_payload_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  // hold the result until taken; bytes without a result leave it empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_take) begin
      out_v_r <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_r.error_code, out_r.frame_type, out_r.data_out};
  assign out_tlast  = out_r.last;
  assign out_tuser  = out_r.kind;

endmodule

// File: src/wsfd_parser.sv
// ----------------------------------------------------------------------------
// wsfd_parser: frame header parser and payload unmasker
// Holds the parse state and steps it by one byte; gives at most one result.
// ----------------------------------------------------------------------------
module wsfd_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         data_byte,
  input  logic [31:0]        max_payload,
  input  logic [7:0]         min_payload,
  output logic               res_valid,
  output wsfd_pkg::res_t     res
);

  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  opc_r, opc_nxt;
  logic [63:0] len_r, len_nxt;
  logic [2:0]  fbc_r, fbc_nxt;
  logic        ext_long_r, ext_long_nxt;
  logic [31:0] key_r, key_nxt;
  logic [31:0] pc_r, pc_nxt;
  logic        stopped_r, stopped_nxt;

  logic [63:0] len_cand;
  logic        too_big;
  logic        too_small;
  logic [7:0]  key_byte;
  logic [2:0]  ext_need;

  // candidate complete length for the header byte and the extended field
  always_comb begin
    if (phase_r == wsfd_pkg::PH_HDR1) begin
      len_cand = {57'd0, data_byte[6:0]};
    end else begin
      len_cand = {len_r[55:0], data_byte};
    end
    too_big   = (|len_cand[63:32]) || (len_cand[31:0] > max_payload);
    too_small = len_cand < {56'd0, min_payload};
    ext_need  = ext_long_r ? 3'd0 : 3'd2;
  end

  always_comb begin
    unique case (pc_r[1:0])
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    logic len_done;
    len_done     = 1'b0;
    phase_nxt    = phase_r;
    opc_nxt      = opc_r;
    len_nxt      = len_r;
    fbc_nxt      = fbc_r;
    ext_long_nxt = ext_long_r;
    key_nxt      = key_r;
    pc_nxt       = pc_r;
    stopped_nxt  = stopped_r;
    res_valid    = 1'b0;
    res.kind       = wsfd_pkg::KIND_PAYLOAD;
    res.data_out   = 8'd0;
    res.last       = 1'b0;
    res.error_code = wsfd_pkg::ERR_NONE;

    if (step && !stopped_r) begin
      unique case (phase_r)
        wsfd_pkg::PH_HDR0: begin
          opc_nxt = data_byte[3:0];
          len_nxt = '0;
          pc_nxt  = '0;
          key_nxt = '0;
          fbc_nxt = '0;
          unique case (data_byte[3:0])
            wsfd_pkg::OPC_TEXT, wsfd_pkg::OPC_BIN: begin
              phase_nxt = wsfd_pkg::PH_HDR1;
            end
            wsfd_pkg::OPC_CLOSE: begin
              stopped_nxt = 1'b1;
              res_valid   = 1'b1;
              res.kind    = wsfd_pkg::KIND_CLOSE;
              res.last    = 1'b1;
            end
            wsfd_pkg::OPC_CONT, wsfd_pkg::OPC_PING, wsfd_pkg::OPC_PONG: begin
              stopped_nxt    = 1'b1;
              res_valid      = 1'b1;
              res.kind       = wsfd_pkg::KIND_ERROR;
              res.last       = 1'b1;
              res.error_code = wsfd_pkg::ERR_UNSUPP;
            end
            default: begin
              stopped_nxt    = 1'b1;
              res_valid      = 1'b1;
              res.kind       = wsfd_pkg::KIND_ERROR;
              res.last       = 1'b1;
              res.error_code = wsfd_pkg::ERR_INVALID;
            end
          endcase
        end
        wsfd_pkg::PH_HDR1: begin
          if (data_byte[6:0] == wsfd_pkg::LEN_EXT16) begin
            ext_long_nxt = 1'b0;
            fbc_nxt      = '0;
            phase_nxt    = wsfd_pkg::PH_EXTLEN;
          end else if (data_byte[6:0] == wsfd_pkg::LEN_EXT64) begin
            ext_long_nxt = 1'b1;
            fbc_nxt      = '0;
            phase_nxt    = wsfd_pkg::PH_EXTLEN;
          end else begin
            len_nxt  = len_cand;
            len_done = 1'b1;
          end
        end
        wsfd_pkg::PH_EXTLEN: begin
          len_nxt = len_cand;
          fbc_nxt = fbc_r + 3'd1;
          // the 3-bit count wraps to zero after the eighth byte
          len_done = (fbc_nxt == ext_need);
        end
        wsfd_pkg::PH_MASK: begin
          key_nxt = {key_r[23:0], data_byte};
          fbc_nxt = fbc_r + 3'd1;
          if (fbc_nxt[2]) begin
            fbc_nxt = '0;
            pc_nxt  = '0;
            if (len_r == 64'd0) begin
              phase_nxt = wsfd_pkg::PH_HDR0;
              res_valid = 1'b1;
              res.kind  = wsfd_pkg::KIND_EMPTY;
              res.last  = 1'b1;
            end else begin
              phase_nxt = wsfd_pkg::PH_PAYLOAD;
            end
          end
        end
        wsfd_pkg::PH_PAYLOAD: begin
          pc_nxt       = pc_r + 32'd1;
          res_valid    = 1'b1;
          res.kind     = wsfd_pkg::KIND_PAYLOAD;
          res.data_out = data_byte ^ key_byte;
          // length passed the limit check, so it fits in 32 bits here
          if (pc_nxt >= len_r[31:0]) begin
            phase_nxt = wsfd_pkg::PH_HDR0;
            res.last  = 1'b1;
          end
        end
        default: begin
          phase_nxt = wsfd_pkg::PH_HDR0;
        end
      endcase

      if (len_done) begin
        priority if (too_big) begin
          stopped_nxt    = 1'b1;
          res_valid      = 1'b1;
          res.kind       = wsfd_pkg::KIND_ERROR;
          res.last       = 1'b1;
          res.error_code = wsfd_pkg::ERR_TOOLARGE;
        end else if (too_small) begin
          stopped_nxt    = 1'b1;
          res_valid      = 1'b1;
          res.kind       = wsfd_pkg::KIND_ERROR;
          res.last       = 1'b1;
          res.error_code = wsfd_pkg::ERR_TOOSMALL;
        end else begin
          phase_nxt = wsfd_pkg::PH_MASK;
          fbc_nxt   = '0;
        end
      end
    end
    res.frame_type = opc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= wsfd_pkg::PH_HDR0;
      opc_r      <= '0;
      len_r      <= '0;
      fbc_r      <= '0;
      ext_long_r <= 1'b0;
      key_r      <= '0;
      pc_r       <= '0;
      stopped_r  <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      opc_r      <= opc_nxt;
      len_r      <= len_nxt;
      fbc_r      <= fbc_nxt;
      ext_long_r <= ext_long_nxt;
      key_r      <= key_nxt;
      pc_r       <= pc_nxt;
      stopped_r  <= stopped_nxt;
    end
  end

endmodule

// File: test/websocket_frame_deframer_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top_test: self-checking bench for the frame deframer
// Streams well-formed WebSocket frames with random headers, length encodings,
// mask keys and payloads through the block under several length limits, then
// ends the stream with one randomly chosen stop condition (close or error).
// Every result is checked against an in-bench parser model.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top_test;

  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {RX_STEADY, RX_COIN, RX_THREE_IN_FOUR, RX_SPARSE} rx_mode_t;
  typedef enum int {STOP_CLOSE, STOP_UNSUPP, STOP_INVALID, STOP_TOO_LARGE,
                    STOP_TOO_SMALL} stop_kind_t;

  // Parser model plus the queue of results it predicts.
  class deframe_scoreboard;
    logic [31:0]     max_len;
    logic [7:0]      min_len;
    logic [2:0]      phase;
    logic [3:0]      opcode;
    logic [63:0]     length;
    int              field_count;
    int              ext_needed;
    logic [31:0]     key;
    logic [31:0]     payload_count;
    bit              stopped;
    wsfd_pkg::res_t  pending_results[$];
    int              mismatches;
    int              checked;

    function new();
      max_len = wsfd_pkg::MAX_PAYLOAD_RESET;
      min_len = wsfd_pkg::MIN_PAYLOAD_RESET;
      phase = wsfd_pkg::PH_HDR0;
      opcode = wsfd_pkg::OPC_CONT;
      length = '0;
      field_count = 0;
      ext_needed = 0;
      key = '0;
      payload_count = '0;
      stopped = 1'b0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [7:0] idx, logic [31:0] val);
      if (idx == wsfd_pkg::REG_MAX_PAYLOAD) begin
        max_len = val;
      end else if (idx == wsfd_pkg::REG_MIN_PAYLOAD) begin
        min_len = val[7:0];
      end
    endfunction

    function void add_result(logic [1:0] kind, logic [7:0] data, logic last,
                             logic [2:0] err);
      wsfd_pkg::res_t r;
      r.kind = kind;
      r.data_out = data;
      r.last = last;
      r.frame_type = opcode;
      r.error_code = err;
      pending_results.push_back(r);
    endfunction

    function void stop_with(logic [2:0] err);
      stopped = 1'b1;
      add_result(wsfd_pkg::KIND_ERROR, 8'h00, 1'b1, err);
    endfunction

    // Limits are checked as soon as the length field is complete.
    function void length_complete();
      if (length > {32'h0, max_len}) begin
        stop_with(wsfd_pkg::ERR_TOOLARGE);
      end else if (length < {56'h0, min_len}) begin
        stop_with(wsfd_pkg::ERR_TOOSMALL);
      end else begin
        phase = wsfd_pkg::PH_MASK;
        field_count = 0;
      end
    endfunction

    function void note_byte(logic [7:0] b);
      logic [7:0] key_byte;
      if (stopped) return;
      case (phase)
        wsfd_pkg::PH_HDR0: begin
          opcode = b[3:0];
          length = '0;
          payload_count = '0;
          key = '0;
          field_count = 0;
          if (opcode == wsfd_pkg::OPC_TEXT || opcode == wsfd_pkg::OPC_BIN) begin
            phase = wsfd_pkg::PH_HDR1;
          end else if (opcode == wsfd_pkg::OPC_CLOSE) begin
            stopped = 1'b1;
            add_result(wsfd_pkg::KIND_CLOSE, 8'h00, 1'b1, wsfd_pkg::ERR_NONE);
          end else if (opcode == wsfd_pkg::OPC_CONT || opcode == wsfd_pkg::OPC_PING ||
                       opcode == wsfd_pkg::OPC_PONG) begin
            stop_with(wsfd_pkg::ERR_UNSUPP);
          end else begin
            stop_with(wsfd_pkg::ERR_INVALID);
          end
        end
        wsfd_pkg::PH_HDR1: begin
          if (b[6:0] == wsfd_pkg::LEN_EXT16 || b[6:0] == wsfd_pkg::LEN_EXT64) begin
            ext_needed = (b[6:0] == wsfd_pkg::LEN_EXT16) ? 2 : 8;
            field_count = 0;
            phase = wsfd_pkg::PH_EXTLEN;
          end else begin
            length = {57'h0, b[6:0]};
            length_complete();
          end
        end
        wsfd_pkg::PH_EXTLEN: begin
          length = {length[55:0], b};
          field_count++;
          if (field_count == ext_needed) length_complete();
        end
        wsfd_pkg::PH_MASK: begin
          key = {key[23:0], b};
          field_count++;
          if (field_count == 4) begin
            field_count = 0;
            payload_count = '0;
            if (length == 0) begin
              phase = wsfd_pkg::PH_HDR0;
              add_result(wsfd_pkg::KIND_EMPTY, 8'h00, 1'b1, wsfd_pkg::ERR_NONE);
            end else begin
              phase = wsfd_pkg::PH_PAYLOAD;
            end
          end
        end
        wsfd_pkg::PH_PAYLOAD: begin
          // key bytes are applied most significant first
          key_byte = key[8 * (3 - payload_count[1:0]) +: 8];
          payload_count++;
          if ({32'h0, payload_count} >= length) begin
            phase = wsfd_pkg::PH_HDR0;
            add_result(wsfd_pkg::KIND_PAYLOAD, b ^ key_byte, 1'b1, wsfd_pkg::ERR_NONE);
          end else begin
            add_result(wsfd_pkg::KIND_PAYLOAD, b ^ key_byte, 1'b0, wsfd_pkg::ERR_NONE);
          end
        end
        default: phase = wsfd_pkg::PH_HDR0;
      endcase
    endfunction

    function void check_result(wsfd_pkg::res_t got);
      wsfd_pkg::res_t want;
      checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: kind %0d data %02h last %0b type %0h err %0d",
                   $time, got.kind, got.data_out, got.last, got.frame_type,
                   got.error_code);
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind || got.data_out !== want.data_out ||
          got.last !== want.last || got.frame_type !== want.frame_type ||
          got.error_code !== want.error_code) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"[%0t] result mismatch: expected kind %0d data %02h last %0b type %0h",
                    " err %0d, got kind %0d data %02h last %0b type %0h err %0d"},
                   $time, want.kind, want.data_out, want.last, want.frame_type,
                   want.error_code, got.kind, got.data_out, got.last, got.frame_type,
                   got.error_code);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = 8'h00;
  logic [31:0] cfg_data = 32'h0;

  deframe_scoreboard sb;
  int          burst_left = 1;
  int          gap_left = 0;
  int          bytes_sent = 0;
  int          frames_sent = 0;
  int          cycle_count = 0;
  bit          hold_req = 1'b0;
  stop_kind_t  stop_kind;

  websocket_frame_deframer_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               sb.pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // Handshakes are sampled at the falling edge, where every signal is settled
  // for the next rising edge.
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(wsfd_pkg::res_t'{kind: out_tuser, data_out: out_tdata[7:0],
                                       last: out_tlast, frame_type: out_tdata[11:8],
                                       error_code: out_tdata[14:12]});
  end

  // Receiver: stall pattern of its own, plus a long hold-off on request.
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    mode = RX_STEADY;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 150;
      end
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          RX_STEADY:        out_tready <= 1'b1;
          RX_COIN:          out_tready <= 1'($urandom_range(0, 1));
          RX_THREE_IN_FOUR: out_tready <= (mode_left % 4) != 0;
          default:          out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one byte; bursts of random length separated by random gaps.
  task automatic offer_byte(input logic [7:0] b, input bit counted);
    bit fire;
    if (gap_left > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do begin
      @(negedge clk);
      fire = in_tready;
      if (fire) sb.note_byte(b);
      @(posedge clk);
    end while (!fire);
    if (counted) bytes_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) == 0)
        gap_left = 0;
      else
        gap_left = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 25 : 4);
    end
  endtask

  task automatic sender_idle();
    in_tvalid <= 1'b0;
  endtask

  // Drain every pending result, then let the pipeline settle.
  task automatic quiesce();
    sender_idle();
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_limits(input logic [31:0] maxv, input logic [7:0] minv);
    bit          fire;
    logic [7:0]  idx;
    logic [31:0] val;
    quiesce();
    for (int r = 0; r < 2; r++) begin
      idx = (r == 0) ? wsfd_pkg::REG_MAX_PAYLOAD : wsfd_pkg::REG_MIN_PAYLOAD;
      val = (r == 0) ? maxv : {24'h0, minv};
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= val;
      do begin
        @(negedge clk);
        fire = cfg_ready;
        if (fire) sb.set_reg(idx, val);
        @(posedge clk);
      end while (!fire);
    end
    cfg_valid <= 1'b0;
  endtask

  // enc: 0 seven-bit length, 1 sixteen-bit extension, 2 sixty-four-bit extension
  task automatic send_header(input logic [3:0] opc, input logic [63:0] len, input int enc);
    logic mask_bit;
    mask_bit = 1'($urandom_range(0, 1));
    offer_byte({4'($urandom_range(0, 15)), opc}, 1'b1);
    case (enc)
      0: offer_byte({mask_bit, len[6:0]}, 1'b1);
      1: begin
        offer_byte({mask_bit, wsfd_pkg::LEN_EXT16}, 1'b1);
        offer_byte(len[15:8], 1'b1);
        offer_byte(len[7:0], 1'b1);
      end
      default: begin
        offer_byte({mask_bit, wsfd_pkg::LEN_EXT64}, 1'b1);
        for (int i = 7; i >= 0; i--) offer_byte(len[8 * i +: 8], 1'b1);
      end
    endcase
  endtask

  task automatic send_frame(input logic [3:0] opc, input logic [63:0] len, input int enc,
                            input logic [31:0] key);
    send_header(opc, len, enc);
    for (int i = 3; i >= 0; i--) offer_byte(key[8 * i +: 8], 1'b1);
    for (longint i = 0; i < len; i++) offer_byte(8'($urandom_range(0, 255)), 1'b1);
    frames_sent++;
  endtask

  // Well-formed frame inside the current limits; mostly short payloads.
  task automatic send_random_frame();
    longint      lo;
    longint      hi;
    longint      cap;
    int          r;
    int          enc;
    logic [63:0] len;
    logic [31:0] key;
    logic [3:0]  opc;
    lo = sb.min_len;
    hi = sb.max_len;
    r = $urandom_range(0, 99);
    cap = (r < 70) ? 16 : (r < 95) ? 130 : 300;
    if (hi - lo > cap) hi = lo + cap;
    len = $urandom_range(int'(lo), int'(hi));
    enc = (len <= 125) ? $urandom_range(0, 2) : $urandom_range(1, 2);
    r = $urandom_range(0, 9);
    key = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
    opc = $urandom_range(0, 1) ? wsfd_pkg::OPC_TEXT : wsfd_pkg::OPC_BIN;
    send_frame(opc, len, enc, key);
  endtask

  task automatic run_phase(input logic [31:0] maxv, input logic [7:0] minv, input int budget);
    int start;
    set_limits(maxv, minv);
    start = bytes_sent;
    while (bytes_sent - start < budget) send_random_frame();
  endtask

  // End the stream with a close or an error, then feed bytes that must be dropped.
  task automatic send_stop_event();
    logic [3:0]  opc;
    logic [63:0] len;
    logic [31:0] maxv;
    logic [7:0]  minv;
    int          enc;
    stop_kind = stop_kind_t'($urandom_range(0, 4));
    case (stop_kind)
      STOP_CLOSE: offer_byte({4'($urandom_range(0, 15)), wsfd_pkg::OPC_CLOSE}, 1'b1);
      STOP_UNSUPP: begin
        case ($urandom_range(0, 2))
          0:       opc = wsfd_pkg::OPC_CONT;
          1:       opc = wsfd_pkg::OPC_PING;
          default: opc = wsfd_pkg::OPC_PONG;
        endcase
        offer_byte({4'($urandom_range(0, 15)), opc}, 1'b1);
      end
      STOP_INVALID: begin
        do opc = 4'($urandom_range(0, 15));
        while (opc == wsfd_pkg::OPC_CONT || opc == wsfd_pkg::OPC_TEXT ||
               opc == wsfd_pkg::OPC_BIN || opc == wsfd_pkg::OPC_CLOSE ||
               opc == wsfd_pkg::OPC_PING || opc == wsfd_pkg::OPC_PONG);
        offer_byte({4'($urandom_range(0, 15)), opc}, 1'b1);
      end
      STOP_TOO_LARGE: begin
        case ($urandom_range(0, 2))
          0: begin
            maxv = $urandom_range(0, 124);
            len = $urandom_range(maxv + 1, 125);
            enc = $urandom_range(0, 2);
          end
          1: begin
            maxv = $urandom_range(125, 65534);
            len = $urandom_range(maxv + 1, 65535);
            enc = $urandom_range(1, 2);
          end
          default: begin
            // full-range limit: only the upper half of a 64-bit length can exceed it
            maxv = 32'hFFFF_FFFF;
            len[31:0] = $urandom;
            len[63:32] = $urandom_range(0, 1) ? 32'h1 : $urandom_range(1, 32'hFFFF_FFFF);
            enc = 2;
          end
        endcase
        set_limits(maxv, 8'h00);
        send_header($urandom_range(0, 1) ? wsfd_pkg::OPC_TEXT : wsfd_pkg::OPC_BIN, len, enc);
      end
      default: begin
        minv = $urandom_range(1, 255);
        set_limits(32'hFFFF_FFFF, minv);
        len = $urandom_range(0, minv - 1);
        enc = (len <= 125) ? $urandom_range(0, 2) : $urandom_range(1, 2);
        send_header($urandom_range(0, 1) ? wsfd_pkg::OPC_TEXT : wsfd_pkg::OPC_BIN, len, enc);
      end
    endcase
    repeat (20) offer_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  initial begin
    logic [31:0] maxv;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames at the reset limits: empty, 16-bit and 64-bit lengths
    send_frame(wsfd_pkg::OPC_TEXT, 64'd0, 0, 32'h0000_0000);
    send_frame(wsfd_pkg::OPC_BIN, 64'd1, 1, 32'hFFFF_FFFF);
    send_frame(wsfd_pkg::OPC_TEXT, 64'd4, 2, $urandom);

    // long frame while the receiver holds off, so the input backs up
    hold_req = 1'b1;
    send_frame(wsfd_pkg::OPC_BIN, 64'd200, 1, $urandom);

    run_phase(wsfd_pkg::MAX_PAYLOAD_RESET, wsfd_pkg::MIN_PAYLOAD_RESET, 220);
    run_phase(32'hFFFF_FFFF, 8'd0, 300);
    run_phase(32'd0, 8'd0, 120);
    run_phase(32'd300, 8'd255, 1);
    run_phase(32'd17, 8'd17, 120);
    repeat (3) begin
      maxv = $urandom_range(1, 200);
      run_phase(maxv, 8'($urandom_range(0, (maxv < 40) ? maxv : 40)), 150);
    end
    quiesce();
    send_stop_event();

    sender_idle();
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d frames (%0d stream bytes) over eight limit settings; %0d results checked.",
             frames_sent, bytes_sent, sb.checked);
    $display("Stream ended by %s; %0d mismatches.", stop_kind.name(), sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
src/wsfd_pkg.sv
src/wsfd_parser.sv
src/websocket_frame_deframer_top.sv
test/websocket_frame_deframer_top_test.sv
